[hdl/uca_pkg.sv]
// Shared types and constants for the UART command alarm annunciator.
// Holds the command text table, the word op codes and the message codes.
// No dependencies.
`default_nettype none

package uca_pkg;

  localparam int LINE_CAPACITY_DEF = 32;
  localparam int QUEUE_DEPTH       = 2;
  localparam int NUM_CMDS          = 10;
  localparam int CMD_TEXT_W        = 128;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Command line indexes into the text table
  localparam int CMD_DUMP_START = 0;
  localparam int CMD_DUMP_END   = 1;
  localparam int CMD_LOGIN      = 2;
  localparam int CMD_FAILURE    = 3;
  localparam int CMD_LOCKOUT    = 4;
  localparam int CMD_BREACH     = 5;
  localparam int CMD_TAMPER     = 6;
  localparam int CMD_PFAIL      = 7;
  localparam int CMD_PRESTORE   = 8;
  localparam int CMD_WDT        = 9;

  localparam logic [CMD_TEXT_W-1:0] CMD_TEXT [NUM_CMDS] = '{
    CMD_TEXT_W'("=== LOG DUMP ==="),
    CMD_TEXT_W'("=== END ==="),
    CMD_TEXT_W'({"LOGIN", "_OK"}),
    CMD_TEXT_W'("FAILURE"),
    CMD_TEXT_W'({"LOCKOUT", "_END"}),
    CMD_TEXT_W'("BREACH"),
    CMD_TEXT_W'("Tamper"),
    CMD_TEXT_W'({"POWER", "_FAIL"}),
    CMD_TEXT_W'("POWER RESTORED"),
    CMD_TEXT_W'({"WDT", "_RESET"})
  };

  localparam int CMD_LEN [NUM_CMDS] = '{16, 11, 8, 7, 11, 6, 6, 10, 14, 9};

  // Message codes shown on the display
  localparam logic [2:0] MSG_GRANTED   = 3'd0;
  localparam logic [2:0] MSG_WRONG_PW  = 3'd1;
  localparam logic [2:0] MSG_WAITING   = 3'd2;
  localparam logic [2:0] MSG_BREACH    = 3'd3;
  localparam logic [2:0] MSG_TAMPER    = 3'd4;
  localparam logic [2:0] MSG_PWR_FAIL  = 3'd5;
  localparam logic [2:0] MSG_RESTORED  = 3'd6;
  localparam logic [2:0] MSG_RESTARTED = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_SUCCESS = 2'd0;
  localparam logic [1:0] REG_REMOTE  = 2'd1;
  localparam logic [1:0] REG_BREACH  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_LOGIN,
    OP_FAILURE,
    OP_LOCKOUT,
    OP_BREACH,
    OP_TAMPER,
    OP_PFAIL,
    OP_PRESTORE,
    OP_WDT
  } op_t;

  // Character p of command k; only meaningful for p below the command length
  function automatic logic [7:0] cmd_char(input int k, input int p);
    int                    sh;
    logic [CMD_TEXT_W-1:0] txt;
    txt = CMD_TEXT[k];
    if (p < CMD_LEN[k]) begin
      sh = 8 * (CMD_LEN[k] - 1 - p);
      return txt[sh +: 8];
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

[hdl/uca_front.sv]
// Front end: accepts words, assembles lines and classifies them into ops.
// Matches every command incrementally as bytes arrive. Uses uca_pkg.
`default_nettype none

module uca_front #(
  parameter int LINE_CAPACITY = uca_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         req_type,
  input  wire logic [7:0]   rx_byte,
  output logic              push_valid,
  input  wire logic         push_ready,
  output uca_pkg::op_t      push_op
);
  import uca_pkg::*;

  localparam int FILL_W = $clog2(LINE_CAPACITY + 1);

  logic [FILL_W-1:0]   fill, fill_next;
  logic                too_long, too_long_next;
  logic                in_log, in_log_next;
  logic [NUM_CMDS-1:0] match, match_next;
  logic [NUM_CMDS-1:0] hit;
  logic                accept;
  logic                is_term;
  op_t                 op;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_op    = op;
  assign accept     = in_valid && push_ready;
  assign is_term    = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);

  // Whole-line match: every byte so far agreed and the length is exact
  always_comb begin
    for (int k = 0; k < NUM_CMDS; k++) begin
      hit[k] = match[k] && (fill == FILL_W'(CMD_LEN[k]));
    end
  end

  always_comb begin
    op            = OP_NONE;
    fill_next     = fill;
    too_long_next = too_long;
    in_log_next   = in_log;
    match_next    = match;
    if (req_type) begin
      op = OP_TICK;
    end else if (is_term) begin
      if (!too_long && fill != '0) begin
        if (hit[CMD_DUMP_START]) begin
          in_log_next = 1'b1;
        end else if (in_log) begin
          if (hit[CMD_DUMP_END]) in_log_next = 1'b0;
        end else if (hit[CMD_LOGIN]) begin
          op = OP_LOGIN;
        end else if (hit[CMD_FAILURE]) begin
          op = OP_FAILURE;
        end else if (hit[CMD_LOCKOUT]) begin
          op = OP_LOCKOUT;
        end else if (hit[CMD_BREACH]) begin
          op = OP_BREACH;
        end else if (hit[CMD_TAMPER]) begin
          op = OP_TAMPER;
        end else if (hit[CMD_PFAIL]) begin
          op = OP_PFAIL;
        end else if (hit[CMD_PRESTORE]) begin
          op = OP_PRESTORE;
        end else if (hit[CMD_WDT]) begin
          op = OP_WDT;
        end
      end
      fill_next     = '0;
      too_long_next = 1'b0;
      match_next    = '1;
    end else if (!too_long) begin
      if (fill < FILL_W'(LINE_CAPACITY)) begin
        for (int k = 0; k < NUM_CMDS; k++) begin
          match_next[k] = match[k] && (int'(fill) < CMD_LEN[k]) &&
                          (rx_byte == cmd_char(k, int'(fill)));
        end
        fill_next = fill + FILL_W'(1);
      end else begin
        // Drop the line up to its terminator
        too_long_next = 1'b1;
        fill_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      too_long <= 1'b0;
      in_log   <= 1'b0;
      match    <= '1;
    end else if (accept) begin
      fill     <= fill_next;
      too_long <= too_long_next;
      in_log   <= in_log_next;
      match    <= match_next;
    end
  end

endmodule

`default_nettype wire

[hdl/uca_queue.sv]
// Short op queue between the front end and the back end.
// Two entries, so each side can stall on its own. Uses uca_pkg.
`default_nettype none

module uca_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire uca_pkg::op_t push_op,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output uca_pkg::op_t      pop_op
);
  import uca_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

[hdl/uca_back.sv]
// Back end: carries out ops on the timers and indicators, holds the
// configuration registers and the output word register. Uses uca_pkg.
`default_nettype none

module uca_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         pop_valid,
  output logic              pop_ready,
  input  wire uca_pkg::op_t pop_op,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              green_lamp,
  output logic              red_led,
  output logic              buzzer,
  output logic              message_valid,
  output logic [2:0]        message_code
);
  import uca_pkg::*;

  logic [7:0] success_secs, remote_secs, breach_secs;

  logic       short_on, short_on_next;
  logic       power_on, power_on_next;
  logic       success_on, success_on_next;
  logic [7:0] alarm_left, alarm_left_next;
  logic [7:0] green_left, green_left_next;
  logic       drv_green, drv_green_next;
  logic       drv_red, drv_red_next;
  logic       drv_buz, drv_buz_next;
  logic       msg_v;
  logic [2:0] msg_code;
  logic       pop;
  logic       alarm_start;
  logic [7:0] alarm_secs;

  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    short_on_next   = short_on;
    power_on_next   = power_on;
    success_on_next = success_on;
    alarm_left_next = alarm_left;
    green_left_next = green_left;
    drv_green_next  = drv_green;
    drv_red_next    = drv_red;
    drv_buz_next    = drv_buz;
    msg_v           = 1'b0;
    msg_code        = MSG_GRANTED;
    alarm_start     = 1'b0;
    alarm_secs      = remote_secs;

    case (pop_op)
      OP_TICK: begin
        if (alarm_left != 8'd0) alarm_left_next = alarm_left - 8'd1;
        if (green_left != 8'd0) green_left_next = green_left - 8'd1;
      end
      OP_LOGIN: begin
        msg_v    = 1'b1;
        msg_code = MSG_GRANTED;
        if (!power_on) begin
          drv_green_next  = 1'b1;
          drv_red_next    = 1'b0;
          drv_buz_next    = 1'b0;
          short_on_next   = 1'b0;
          alarm_left_next = 8'd0;
          success_on_next = 1'b1;
          green_left_next = success_secs;
        end
      end
      OP_FAILURE: begin
        msg_v       = 1'b1;
        msg_code    = MSG_WRONG_PW;
        alarm_start = 1'b1;
      end
      OP_LOCKOUT: begin
        msg_v           = 1'b1;
        msg_code        = MSG_WAITING;
        short_on_next   = 1'b0;
        alarm_left_next = 8'd0;
        drv_red_next    = 1'b0;
        drv_buz_next    = 1'b0;
      end
      OP_BREACH: begin
        msg_v       = 1'b1;
        msg_code    = MSG_BREACH;
        alarm_start = 1'b1;
        alarm_secs  = breach_secs;
      end
      OP_TAMPER: begin
        msg_v       = 1'b1;
        msg_code    = MSG_TAMPER;
        alarm_start = 1'b1;
      end
      OP_PFAIL: begin
        msg_v           = 1'b1;
        msg_code        = MSG_PWR_FAIL;
        power_on_next   = 1'b1;
        short_on_next   = 1'b0;
        success_on_next = 1'b0;
        alarm_left_next = 8'd0;
        green_left_next = 8'd0;
        drv_green_next  = 1'b0;
        drv_red_next    = 1'b1;
        drv_buz_next    = 1'b1;
      end
      OP_PRESTORE: begin
        msg_v           = 1'b1;
        msg_code        = MSG_RESTORED;
        power_on_next   = 1'b0;
        short_on_next   = 1'b0;
        success_on_next = 1'b0;
        alarm_left_next = 8'd0;
        green_left_next = 8'd0;
        drv_green_next  = 1'b0;
        drv_red_next    = 1'b0;
        drv_buz_next    = 1'b0;
      end
      OP_WDT: begin
        msg_v    = 1'b1;
        msg_code = MSG_RESTARTED;
      end
      default: begin
      end
    endcase

    // Held power alarm blocks temporary alarms
    if (alarm_start && !power_on) begin
      drv_green_next  = 1'b0;
      drv_red_next    = 1'b1;
      drv_buz_next    = 1'b1;
      success_on_next = 1'b0;
      green_left_next = 8'd0;
      short_on_next   = 1'b1;
      alarm_left_next = alarm_secs;
    end

    // Expire timers that have reached zero
    if (short_on_next && alarm_left_next == 8'd0) begin
      short_on_next = 1'b0;
      drv_red_next  = 1'b0;
      drv_buz_next  = 1'b0;
    end
    if (success_on_next && green_left_next == 8'd0) begin
      success_on_next = 1'b0;
      drv_green_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      success_secs <= 8'd3;
      remote_secs  <= 8'd5;
      breach_secs  <= 8'd10;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SUCCESS: success_secs <= cfg_data;
        REG_REMOTE:  remote_secs  <= cfg_data;
        REG_BREACH:  breach_secs  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_on   <= 1'b0;
      power_on   <= 1'b0;
      success_on <= 1'b0;
      alarm_left <= 8'd0;
      green_left <= 8'd0;
      drv_green  <= 1'b0;
      drv_red    <= 1'b0;
      drv_buz    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        short_on   <= short_on_next;
        power_on   <= power_on_next;
        success_on <= success_on_next;
        alarm_left <= alarm_left_next;
        green_left <= green_left_next;
        drv_green  <= drv_green_next;
        drv_red    <= drv_red_next;
        drv_buz    <= drv_buz_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (pop) begin
      green_lamp    <= drv_green_next;
      red_led       <= drv_red_next;
      buzzer        <= drv_buz_next;
      message_valid <= msg_v;
      message_code  <= msg_code;
    end
  end

endmodule

`default_nettype wire

[hdl/uart_command_alarm_annunciator_top.sv]
// UART command alarm annunciator: front end, op queue and back end.
// Throughput: one word per cycle while the queue has room; a word's result is
// registered first in the queue and then in the back end's output register.
// A full two-entry queue holds off input while the output side stalls.
// Reset is synchronous: clears line state, timers, indicators, and loads
// the default on-times (3, 5 and 10 seconds).
`default_nettype none

module uart_command_alarm_annunciator_top #(
  parameter int LINE_CAPACITY = uca_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       req_type,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            green_lamp,
  output logic            red_led,
  output logic            buzzer,
  output logic            message_valid,
  output logic [2:0]      message_code
);
  import uca_pkg::*;

  logic push_valid, push_ready;
  op_t  push_op;
  logic pop_valid, pop_ready;
  op_t  pop_op;

  uca_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  uca_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  uca_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_op        (pop_op),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .green_lamp    (green_lamp),
    .red_led       (red_led),
    .buzzer        (buzzer),
    .message_valid (message_valid),
    .message_code  (message_code)
  );

endmodule

`default_nettype wire

[tb/uart_command_alarm_annunciator_top_tb.sv]
// Self-checking testbench for uart_command_alarm_annunciator_top: a queue-fed word driver,
// a status monitor and a cycle-free predictor of the line parser, timers and indicators.
// Depends on uca_pkg and the top level only.
`timescale 1ns / 100ps

module uart_command_alarm_annunciator_top_tb;
  import uca_pkg::*;

  localparam int         LINE_CAP  = LINE_CAPACITY_DEF;
  localparam logic       WORD_BYTE = 1'b0;
  localparam logic       WORD_TICK = 1'b1;
  localparam logic [1:0] REG_NONE  = 2'd3;  // index past the last register

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } rx_word_t;

  typedef struct packed {
    logic       green;
    logic       red;
    logic       buzz;
    logic       msg_valid;
    logic [2:0] msg_code;
  } status_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_SUCCESS;
  logic [7:0] cfg_data  = 8'h00;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic       req_type  = WORD_BYTE;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       green_lamp;
  logic       red_led;
  logic       buzzer;
  logic       message_valid;
  logic [2:0] message_code;

  uart_command_alarm_annunciator_top DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .green_lamp(green_lamp), .red_led(red_led), .buzzer(buzzer),
    .message_valid(message_valid), .message_code(message_code)
  );

  rx_word_t word_q [$];
  status_t  status_q [$];

  int words_queued   = 0;
  int words_accepted = 0;
  int statuses_seen  = 0;
  int messages_shown = 0;
  int settings_used  = 1;
  int mismatches     = 0;

  // Predictor state
  logic [7:0]  line_buf [LINE_CAP];
  int unsigned line_len;
  bit          line_overflow, dump_mode, alarm_active, power_held, success_active;
  logic [7:0]  alarm_left, green_left;
  logic        drv_green, drv_red, drv_buzz;
  logic [7:0]  succ_secs, remote_secs, breach_secs;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic string cmd_str(input int k);
    case (k)
      CMD_DUMP_START: return "=== LOG DUMP ===";
      CMD_DUMP_END:   return "=== END ===";
      CMD_LOGIN:      return {"LOGIN", "_OK"};
      CMD_FAILURE:    return "FAILURE";
      CMD_LOCKOUT:    return {"LOCKOUT", "_END"};
      CMD_BREACH:     return "BREACH";
      CMD_TAMPER:     return "Tamper";
      CMD_PFAIL:      return {"POWER", "_FAIL"};
      CMD_PRESTORE:   return "POWER RESTORED";
      default:        return {"WDT", "_RESET"};
    endcase
  endfunction

  function automatic bit line_is(input int k);
    string s;
    s = cmd_str(k);
    if (s.len() != line_len) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (line_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void start_success(input logic [7:0] secs);
    if (power_held) return;
    {drv_green, drv_red, drv_buzz} = 3'b100;
    alarm_active   = 1'b0;
    alarm_left     = '0;
    success_active = 1'b1;
    green_left     = secs;
  endfunction

  function automatic void start_alarm(input logic [7:0] secs);
    if (power_held) return;
    {drv_green, drv_red, drv_buzz} = 3'b011;
    success_active = 1'b0;
    green_left     = '0;
    alarm_active   = 1'b1;
    alarm_left     = secs;
  endfunction

  function automatic void apply_line(output bit mv, output logic [2:0] mc);
    mv = 1'b1;
    mc = '0;
    if (line_is(CMD_DUMP_START)) begin
      dump_mode = 1'b1;
      mv = 1'b0;
    end else if (dump_mode) begin
      if (line_is(CMD_DUMP_END)) dump_mode = 1'b0;
      mv = 1'b0;
    end else if (line_is(CMD_LOGIN)) begin
      start_success(succ_secs);
      mc = MSG_GRANTED;
    end else if (line_is(CMD_FAILURE)) begin
      start_alarm(remote_secs);
      mc = MSG_WRONG_PW;
    end else if (line_is(CMD_LOCKOUT)) begin
      alarm_active = 1'b0;
      alarm_left   = '0;
      drv_red      = 1'b0;
      drv_buzz     = 1'b0;
      mc = MSG_WAITING;
    end else if (line_is(CMD_BREACH)) begin
      start_alarm(breach_secs);
      mc = MSG_BREACH;
    end else if (line_is(CMD_TAMPER)) begin
      start_alarm(remote_secs);
      mc = MSG_TAMPER;
    end else if (line_is(CMD_PFAIL) || line_is(CMD_PRESTORE)) begin
      // power fail latches red and buzzer; restore clears everything
      power_held     = line_is(CMD_PFAIL);
      alarm_active   = 1'b0;
      success_active = 1'b0;
      alarm_left     = '0;
      green_left     = '0;
      {drv_green, drv_red, drv_buzz} = power_held ? 3'b011 : 3'b000;
      mc = power_held ? MSG_PWR_FAIL : MSG_RESTORED;
    end else if (line_is(CMD_WDT)) begin
      mc = MSG_RESTARTED;
    end else begin
      mv = 1'b0;
    end
  endfunction

  function automatic status_t step_annunciator(input rx_word_t w);
    status_t    r;
    bit         mv;
    logic [2:0] mc;
    mv = 1'b0;
    mc = '0;
    if (w.kind == WORD_TICK) begin
      if (alarm_left != 0) alarm_left--;
      if (green_left != 0) green_left--;
    end else if (w.ch == CHAR_CR || w.ch == CHAR_LF) begin
      if (!line_overflow && line_len > 0) apply_line(mv, mc);
      line_len      = 0;
      line_overflow = 1'b0;
    end else if (!line_overflow) begin
      if (line_len < LINE_CAP) begin
        line_buf[line_len] = w.ch;
        line_len++;
      end else begin
        line_overflow = 1'b1;
        line_len      = 0;
      end
    end
    // expire timers that have run out, including ones started at zero
    if (alarm_active && alarm_left == 0) begin
      alarm_active = 1'b0;
      drv_red      = 1'b0;
      drv_buzz     = 1'b0;
    end
    if (success_active && green_left == 0) begin
      success_active = 1'b0;
      drv_green      = 1'b0;
    end
    r.green     = drv_green;
    r.red       = drv_red;
    r.buzz      = drv_buzz;
    r.msg_valid = mv;
    r.msg_code  = mc;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: result %0d: %s", $time, statuses_seen, what);
    mismatches++;
  endtask

  // Word driver: offer the next queued word, hold it until it is taken
  always @(posedge clk) begin : drive_words
    rx_word_t nxt;
    status_t  predicted;
    bit       offering;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        predicted = step_annunciator(rx_word_t'{req_type, rx_byte});
        status_q.push_back(predicted);
        if (predicted.msg_valid) messages_shown++;
        words_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (word_q.size() != 0 &&
            ((words_accepted > 500 && words_accepted < 850) || $urandom_range(0, 99) >= 29)) begin
          nxt = word_q.pop_front();
          req_type <= nxt.kind;
          rx_byte  <= nxt.ch;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor with random stalls and two long hold-offs
  always @(posedge clk) begin : check_status
    status_t want;
    int      hold_left;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = status_q.pop_front();
          if (green_lamp !== want.green)
            report_mismatch($sformatf("green_lamp %b, expected %b", green_lamp, want.green));
          if (red_led !== want.red)
            report_mismatch($sformatf("red_led %b, expected %b", red_led, want.red));
          if (buzzer !== want.buzz)
            report_mismatch($sformatf("buzzer %b, expected %b", buzzer, want.buzz));
          if (message_valid !== want.msg_valid)
            report_mismatch($sformatf("message_valid %b, expected %b",
                                      message_valid, want.msg_valid));
          if (message_code !== want.msg_code)
            report_mismatch($sformatf("message_code %0d, expected %0d",
                                      message_code, want.msg_code));
        end
        statuses_seen++;
        if (statuses_seen == 300 || statuses_seen == 1100) hold_left = 90;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (statuses_seen > 500 && statuses_seen < 850) ||
                     $urandom_range(0, 99) >= 29;
      end
    end
  end

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CHAR_CR || c == CHAR_LF) c = c ^ 8'h80;
    return c;
  endfunction

  task automatic add_word(input logic kind, input logic [7:0] ch);
    word_q.push_back(rx_word_t'{kind, ch});
    words_queued++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_word(WORD_BYTE, s[i]);
  endtask

  task automatic add_eol();
    add_word(WORD_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_word(WORD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SUCCESS: succ_secs   = val;
      REG_REMOTE:  remote_secs = val;
      REG_BREACH:  breach_secs = val;
      default: ;
    endcase
  endtask

  // Every queued word taken and every expected status checked
  task automatic wait_drained();
    do @(posedge clk);
    while (words_accepted != words_queued || status_q.size() != 0);
  endtask

  // Pick one random chunk of traffic; mostly well-formed commands and ticks
  task automatic add_random_chunk();
    string s;
    int    k, at, n;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(0, 19);
      k = (n == 0) ? CMD_DUMP_START : (n < 3) ? CMD_DUMP_END : CMD_LOGIN + (n - 3) % 8;
      add_text(cmd_str(k));
      add_eol();
    end else if (pick < 65) begin
      add_ticks($urandom_range(1, 8));
    end else if (pick < 75) begin
      // near miss: one character replaced, dropped or appended
      s  = cmd_str($urandom_range(0, NUM_CMDS - 1));
      at = $urandom_range(0, s.len() - 1);
      case ($urandom_range(0, 2))
        0: begin
          add_text(s.substr(0, at - 1));
          add_word(WORD_BYTE, line_char());
          add_text(s.substr(at + 1, s.len() - 1));
        end
        1: add_text(s.substr(0, s.len() - 2));
        default: begin
          add_text(s);
          add_word(WORD_BYTE, line_char());
        end
      endcase
      add_eol();
    end else if (pick < 83) begin
      repeat ($urandom_range(0, 10)) add_word(WORD_BYTE, line_char());
      add_eol();
    end else if (pick < 88) begin
      // lengths around the line capacity, sometimes with a command tail
      n = $urandom_range(0, 1) ? LINE_CAP - 1 + $urandom_range(0, 2)
                               : LINE_CAP + $urandom_range(2, 12);
      repeat (n) add_word(WORD_BYTE, line_char());
      if ($urandom_range(0, 1)) add_text(cmd_str($urandom_range(0, NUM_CMDS - 1)));
      add_eol();
    end else if (pick < 93) begin
      add_word(WORD_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      add_text(cmd_str(CMD_LOGIN + $urandom_range(0, 7)));
      add_eol();
      add_ticks($urandom_range(1, 12));
    end
  endtask

  initial begin : stimulus
    int phase;
    succ_secs      = 8'd3;
    remote_secs    = 8'd5;
    breach_secs    = 8'd10;
    line_len       = 0;
    line_overflow  = 1'b0;
    dump_mode      = 1'b0;
    alarm_active   = 1'b0;
    power_held     = 1'b0;
    success_active = 1'b0;
    alarm_left     = '0;
    green_left     = '0;
    {drv_green, drv_red, drv_buzz} = 3'b000;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty line, zero and top byte, login then tamper with a tick between
    add_eol();
    add_word(WORD_BYTE, 8'h00);
    add_word(WORD_BYTE, 8'hFF);
    add_eol();
    add_text(cmd_str(CMD_LOGIN));
    add_eol();
    add_ticks(1);
    add_text(cmd_str(CMD_TAMPER));
    add_eol();
    wait_drained();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SUCCESS, 8'd0);
          write_reg(REG_REMOTE, 8'd0);
          write_reg(REG_BREACH, 8'd0);
          write_reg(REG_NONE, 8'hFF);
        end
        1: begin
          write_reg(REG_SUCCESS, 8'd255);
          write_reg(REG_REMOTE, 8'd255);
          write_reg(REG_BREACH, 8'd255);
        end
        2: begin
          write_reg(REG_SUCCESS, 8'd1);
          write_reg(REG_REMOTE, 8'd2);
          write_reg(REG_BREACH, 8'd3);
        end
        3: begin
          write_reg(REG_SUCCESS, 8'($urandom_range(0, 7)));
          write_reg(REG_REMOTE, 8'($urandom_range(0, 7)));
          write_reg(REG_BREACH, 8'($urandom_range(0, 12)));
        end
        default: begin
          write_reg(REG_SUCCESS, 8'($urandom_range(0, 255)));
          write_reg(REG_REMOTE, 8'($urandom_range(0, 255)));
          write_reg(REG_BREACH, 8'($urandom_range(0, 255)));
        end
      endcase
      settings_used++;
      while (words_queued < 22 + 260 * (phase + 1)) add_random_chunk();
      // sender pauses here until every status is back
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (status_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", status_q.size()));
    $display("Sent %0d words (bytes and ticks) under %0d register settings;",
             words_accepted, settings_used);
    $display("checked %0d status words, %0d of them carrying a command message.",
             statuses_seen, messages_shown);
    if (mismatches == 0)
      $display("uart_command_alarm_annunciator_top test passed");
    else
      $display("uart_command_alarm_annunciator_top test failed");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout with %0d words queued and %0d results outstanding",
             word_q.size(), status_q.size());
    $display("uart_command_alarm_annunciator_top test failed");
    $finish;
  end

endmodule

[uart_command_alarm_annunciator_top.f]
hdl/uca_pkg.sv
hdl/uca_front.sv
hdl/uca_queue.sv
hdl/uca_back.sv
hdl/uart_command_alarm_annunciator_top.sv
tb/uart_command_alarm_annunciator_top_tb.sv
